@@ src/frame_advance_motor_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// frame_advance_motor_sequencer assertion macros
// Shared concurrent assertion forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_ADVANCE_MOTOR_SEQUENCER_ASSERT_SVH
`define FRAME_ADVANCE_MOTOR_SEQUENCER_ASSERT_SVH

// cond must never hold outside reset
`define FAMS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

// when a holds, b holds in the same cycle
`define FAMS_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// when a holds, b holds in the next cycle (no reset disable)
`define FAMS_ASSERT_NEXT(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ src/fams_pkg.sv @@
// ----------------------------------------------------------------------------
// fams_pkg
// Types and codes shared by the frame advance sequencer modules.
// ----------------------------------------------------------------------------
package fams_pkg;

  localparam int NUM_BUTTONS = 4;

  // button slots
  localparam logic [1:0] B_TRIG  = 2'd0;
  localparam logic [1:0] B_DIR   = 2'd1;
  localparam logic [1:0] B_SPEED = 2'd2;
  localparam logic [1:0] B_WAIT  = 2'd3;

  // blink length codes
  localparam logic [1:0] BLINK_SHORT  = 2'd0;
  localparam logic [1:0] BLINK_MEDIUM = 2'd1;
  localparam logic [1:0] BLINK_LONG   = 2'd2;

  // config register indexes
  localparam logic [2:0] R_OPEN_FWD   = 3'd0;
  localparam logic [2:0] R_OPEN_BACK  = 3'd1;
  localparam logic [2:0] R_OPEN_ANGLE = 3'd2;
  localparam logic [2:0] R_EXP_CUTOFF = 3'd3;
  localparam logic [2:0] R_HOLDOFF    = 3'd4;
  localparam logic [2:0] R_LONG_PRESS = 3'd5;
  localparam logic [2:0] R_DOUBLE_TAP = 3'd6;
  localparam logic [2:0] R_MIN_DELAY  = 3'd7;

  localparam logic [15:0] RST_OPEN_FWD   = 16'd19661;
  localparam logic [15:0] RST_OPEN_BACK  = 16'd19661;
  localparam logic [15:0] RST_OPEN_ANGLE = 16'd32768;
  localparam logic [15:0] RST_EXP_CUTOFF = 16'd250;
  localparam logic [11:0] RST_HOLDOFF    = 12'd100;
  localparam logic [15:0] RST_LONG_PRESS = 16'd1000;
  localparam logic [15:0] RST_DOUBLE_TAP = 16'd1000;
  localparam logic [15:0] RST_MIN_DELAY  = 16'd42;

  // one classified tick
  typedef struct packed {
    logic                   sw;
    logic [NUM_BUTTONS-1:0] press;
    logic [NUM_BUTTONS-1:0] rel;
  } item_t;

  typedef struct packed {
    logic run;
    logic lapse;
    logic delaying;
    logic timed;
    logic t_opening;
    logic t_open;
    logic t_closing;
    logic opening;
    logic closing;
    logic bulb;
    logic bulb_run;
    logic primed;
    logic backward;
    logic mfwd;
    logic mback;
  } flags_t;

  typedef struct packed {
    logic        motor_fwd_on;
    logic        motor_back_on;
    logic [1:0]  blink_count;
    logic [1:0]  blink_length;
    logic        is_running;
    logic        is_opening;
    logic        is_closing;
    logic        lapse_active;
    logic        bulb_enabled;
    logic [31:0] frame_total;
    logic [31:0] last_frame_ms;
    logic [31:0] mean_frame_ms;
  } result_t;

endpackage

@@ src/fams_fifo.sv @@
// ----------------------------------------------------------------------------
// fams_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module fams_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/fams_front.sv @@
// ----------------------------------------------------------------------------
// fams_front
// Turns button levels into press and release events per tick.
// ----------------------------------------------------------------------------
module fams_front
  import fams_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  logic  switch_level,
  input  logic  trigger_level,
  input  logic  dir_level,
  input  logic  speed_level,
  input  logic  wait_level,
  output item_t item
);
  logic [NUM_BUTTONS-1:0] button_prev;
  logic [NUM_BUTTONS-1:0] level;

  always_comb begin
    level         = '0;
    level[B_TRIG]  = trigger_level;
    level[B_DIR]   = dir_level;
    level[B_SPEED] = speed_level;
    level[B_WAIT]  = wait_level;
    item.sw    = switch_level;
    item.press = button_prev & ~level;
    item.rel   = ~button_prev & level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_prev <= '1;
    end else if (accept) begin
      button_prev <= level;
    end
  end

endmodule

@@ src/fams_back.sv @@
// ----------------------------------------------------------------------------
// fams_back
// Sequencer core: runs one classified tick per cycle against the state while fired and ready.
// ----------------------------------------------------------------------------
module fams_back
  import fams_pkg::*;
#(
  parameter int TIME_BITS       = 32,
  parameter int TIMED_OFFSET_MS = 379
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          fire,
  output logic          ready,
  input  item_t         item,
  output result_t       result
);
  localparam int TB = TIME_BITS;

  typedef struct packed {
    logic [TB-1:0]                 now;
    logic [TB-1:0]                 st_frame;
    logic [TB-1:0]                 st_open;
    logic [TB-1:0]                 st_delay;
    logic [TB-1:0]                 open_end;
    logic [TB-1:0]                 pause;
    logic [TB-1:0]                 lapse_delay;
    logic [TB-1:0]                 timed_len;
    logic [TB-1:0]                 avg_frame;
    logic [TB-1:0]                 avg_timed;
    logic [TB-1:0]                 frame_len;
    logic [NUM_BUTTONS-1:0][TB-1:0] press_t;
    logic [TB-1:0]                 rel_speed;
    logic [31:0]                   frame_count;
    flags_t                        f;
    logic [1:0]                    bcnt;
    logic [1:0]                    blen;
  } st_t;

  logic [15:0] cfg_open_fwd, cfg_open_back, cfg_open_angle;
  logic [15:0] cfg_exp_cutoff, cfg_long_press, cfg_double_tap, cfg_min_delay;
  logic [11:0] cfg_holdoff;

  logic [TB-1:0] sh_fwd, sh_back, sh_angle;
  logic          dirty;

  st_t st, st_next, st_init;

  function automatic logic [TB-1:0] scale(logic [TB-1:0] v, logic [15:0] q);
    logic [TB-1:0] hi;
    logic [32:0]   lp;
    hi = v >> 16;
    lp = {17'd0, v[15:0]} * {17'd0, q} + 33'd32768;
    return (hi * TB'(q)) + TB'(lp[32:16]);
  endfunction

  function automatic logic [TB-1:0] halve(logic [TB-1:0] a, logic [TB-1:0] b);
    logic [TB:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TB:1];
  endfunction

  function automatic st_t motor_start(st_t s);
    s.f.mfwd  = !s.f.backward;
    s.f.mback = s.f.backward;
    return s;
  endfunction

  function automatic st_t motor_stop(st_t s);
    s.f.mfwd  = 1'b0;
    s.f.mback = 1'b0;
    return s;
  endfunction

  function automatic st_t start_frame(st_t s);
    s.st_frame = s.now;
    if (s.f.timed) begin
      s.f.t_opening = 1'b1;
      s.st_open     = s.now;
      s.open_end    = s.f.backward ? sh_back : sh_fwd;
      s.pause       = s.timed_len - sh_angle;
    end
    s = motor_start(s);
    s.f.run    = 1'b1;
    s.f.primed = 1'b0;
    return s;
  endfunction

  function automatic st_t stop_frame(st_t s);
    s = motor_stop(s);
    s.frame_len = s.now - s.st_frame;
    s.f.run     = 1'b0;
    s.frame_count = s.f.backward ? s.frame_count - 32'd1 : s.frame_count + 32'd1;
    if (s.f.timed) begin
      s.avg_timed   = halve(s.avg_timed, s.frame_len);
      s.f.t_opening = 1'b0;
      s.f.t_open    = 1'b0;
      s.f.t_closing = 1'b0;
    end else begin
      s.avg_frame = halve(s.avg_frame, s.frame_len);
    end
    if (s.f.lapse) begin
      s.f.delaying = 1'b1;
      s.st_delay   = s.now;
    end
    return s;
  endfunction

  function automatic st_t closing_stop(st_t s);
    s = motor_stop(s);
    s.f.closing = 1'b0;
    if (s.f.bulb) begin
      s.avg_timed = halve(s.avg_timed, s.now - s.st_frame);
    end
    return s;
  endfunction

  function automatic st_t read_switch(st_t s, logic lvl);
    if ((s.now - s.st_frame) >= TB'(cfg_holdoff)) begin
      if (!lvl && !s.f.primed) begin
        s.f.primed = 1'b1;
      end else if (lvl && s.f.primed) begin
        if (s.f.run) begin
          s = stop_frame(s);
        end else if (s.f.closing) begin
          s = closing_stop(s);
        end
      end
    end
    return s;
  endfunction

  function automatic st_t bulb_close(st_t s);
    s.f.closing  = 1'b1;
    s.f.opening  = 1'b0;
    s = motor_start(s);
    s.f.bulb_run = 1'b0;
    return s;
  endfunction

  function automatic st_t do_button(st_t s, logic [1:0] b, logic pr, logic rl);
    logic [TB-1:0] held;
    held = s.now - s.press_t[b];
    if (pr) begin
      s.press_t[b] = s.now;
      if (b == B_TRIG) begin
        if (s.f.bulb && !s.f.bulb_run) begin
          s.f.bulb_run = 1'b1;
          s.f.opening  = 1'b1;
          s.f.closing  = 1'b0;
          s.st_open    = s.now;
          s.st_frame   = s.now;
          s.open_end   = s.f.backward ? sh_back : sh_fwd;
          s = motor_start(s);
        end
      end else if (b == B_SPEED) begin
        if ((s.now - s.rel_speed) < TB'(cfg_double_tap)) begin
          s.f.bulb = 1'b1;
          s.bcnt = 2'd1;
          s.blen = BLINK_LONG;
        end else begin
          s.f.bulb = 1'b0;
        end
      end
    end
    if (rl) begin
      unique case (b)
        B_TRIG: begin
          if (held > TB'(cfg_long_press)) begin
            if (!s.f.bulb && !s.f.lapse && !s.f.run) begin
              s.f.lapse = 1'b1;
              s.bcnt = 2'd2;
              s.blen = BLINK_SHORT;
              s = start_frame(s);
            end else if (s.f.bulb && s.f.bulb_run) begin
              s = bulb_close(s);
            end
          end else begin
            s.f.lapse = 1'b0;
            if (s.f.bulb && s.f.bulb_run) begin
              s = bulb_close(s);
            end
            if (!s.f.run && !s.f.bulb) begin
              s = start_frame(s);
            end
          end
        end
        B_WAIT: begin
          if (held < TB'(cfg_min_delay)) begin
            s.lapse_delay = TB'(cfg_min_delay);
            s.bcnt = 2'd1;
            s.blen = BLINK_LONG;
          end else begin
            s.lapse_delay = held;
            s.bcnt = 2'd2;
            s.blen = BLINK_MEDIUM;
          end
        end
        B_SPEED: begin
          if (held < TB'(cfg_exp_cutoff)) begin
            s.timed_len = '0;
            s.f.timed   = 1'b0;
            s.bcnt = 2'd1;
            s.blen = BLINK_LONG;
          end else begin
            s.timed_len = held + TB'(TIMED_OFFSET_MS);
            s.avg_timed = held + TB'(TIMED_OFFSET_MS);
            s.f.timed   = 1'b1;
            s.bcnt = 2'd2;
            s.blen = BLINK_MEDIUM;
          end
          s.rel_speed = s.now;
        end
        B_DIR: begin
          if (held < TB'(cfg_long_press)) begin
            s.f.backward = 1'b0;
            s.bcnt = 2'd1;
            s.blen = BLINK_LONG;
          end else if (held > TB'(cfg_long_press)) begin
            s.f.backward = 1'b1;
            s.bcnt = 2'd2;
            s.blen = BLINK_MEDIUM;
          end
        end
      endcase
    end
    return s;
  endfunction

  // shares of the frame average, one multiply each, registered
  always_ff @(posedge clk) begin
    sh_fwd   <= scale(st.avg_frame, cfg_open_fwd);
    sh_back  <= scale(st.avg_frame, cfg_open_back);
    sh_angle <= scale(st.avg_frame, cfg_open_angle);
  end

  assign ready = !dirty;

  always_comb begin
    st_init             = '0;
    st_init.lapse_delay = TB'(RST_MIN_DELAY);
  end

  always_comb begin
    st_t s;
    s = st;
    s.bcnt = 2'd0;
    s.blen = BLINK_SHORT;
    s = do_button(s, B_TRIG,  item.press[B_TRIG],  item.rel[B_TRIG]);
    s = do_button(s, B_DIR,   item.press[B_DIR],   item.rel[B_DIR]);
    s = do_button(s, B_SPEED, item.press[B_SPEED], item.rel[B_SPEED]);
    s = do_button(s, B_WAIT,  item.press[B_WAIT],  item.rel[B_WAIT]);
    if (s.f.lapse && s.f.delaying && ((s.now - s.st_delay) >= s.lapse_delay)) begin
      s.f.delaying = 1'b0;
      s = start_frame(s);
    end
    if (s.f.run) begin
      if (s.f.timed) begin
        if (s.f.t_opening) begin
          if ((s.now - s.st_frame) >= s.open_end) begin
            s.f.t_open    = 1'b1;
            s.f.t_opening = 1'b0;
            s = motor_stop(s);
          end
        end else if (s.f.t_open) begin
          if ((s.now - s.st_frame) >= (s.open_end + s.pause)) begin
            s = motor_start(s);
            s.f.t_open    = 1'b0;
            s.f.t_closing = 1'b1;
          end
        end else if (s.f.t_closing) begin
          s = read_switch(s, item.sw);
        end
      end else begin
        s = read_switch(s, item.sw);
      end
    end
    if (s.f.opening && ((s.now - s.st_open) >= s.open_end)) begin
      s = motor_stop(s);
      s.f.opening = 1'b0;
    end
    if (s.f.closing) begin
      s = read_switch(s, item.sw);
    end

    result.motor_fwd_on  = s.f.mfwd;
    result.motor_back_on = s.f.mback;
    result.blink_count   = s.bcnt;
    result.blink_length  = s.blen;
    result.is_running    = s.f.run;
    result.is_opening    = s.f.opening;
    result.is_closing    = s.f.closing;
    result.lapse_active  = s.f.lapse;
    result.bulb_enabled  = s.f.bulb;
    result.frame_total   = s.frame_count;
    result.last_frame_ms = 32'(s.frame_len);
    result.mean_frame_ms = s.f.timed ? 32'(s.avg_timed) : 32'(s.avg_frame);

    s.now = s.now + 1'b1;
    st_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= st_init;
      dirty <= 1'b1;
    end else begin
      if (fire) begin
        st <= st_next;
      end
      dirty <= cfg_we || (fire && (st_next.avg_frame != st.avg_frame));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_open_fwd   <= RST_OPEN_FWD;
      cfg_open_back  <= RST_OPEN_BACK;
      cfg_open_angle <= RST_OPEN_ANGLE;
      cfg_exp_cutoff <= RST_EXP_CUTOFF;
      cfg_holdoff    <= RST_HOLDOFF;
      cfg_long_press <= RST_LONG_PRESS;
      cfg_double_tap <= RST_DOUBLE_TAP;
      cfg_min_delay  <= RST_MIN_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        R_OPEN_FWD:   cfg_open_fwd   <= cfg_data;
        R_OPEN_BACK:  cfg_open_back  <= cfg_data;
        R_OPEN_ANGLE: cfg_open_angle <= cfg_data;
        R_EXP_CUTOFF: cfg_exp_cutoff <= cfg_data;
        R_HOLDOFF:    cfg_holdoff    <= cfg_data[11:0];
        R_LONG_PRESS: cfg_long_press <= cfg_data;
        R_DOUBLE_TAP: cfg_double_tap <= cfg_data;
        R_MIN_DELAY:  cfg_min_delay  <= cfg_data;
      endcase
    end
  end

endmodule

@@ src/frame_advance_motor_sequencer.sv @@
// ----------------------------------------------------------------------------
// frame_advance_motor_sequencer
// Film frame advance sequencer stepped by one millisecond tick per transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one tick (switch level plus four button levels, low
// pressed); each tick yields exactly one result transfer with motor enables,
// the blink request and status. A tick normally costs one cycle when the
// result queue has room: the front classifies button edges, a two-entry queue
// feeds the sequencer core, and a two-entry result queue decouples pop. After
// a tick that changes the frame average, or after a configuration write, the
// core holds while the registered open/angle share multipliers settle.
// Configuration is written through cfg_we/cfg_index/cfg_data and takes effect
// immediately; write it only while idle.
module frame_advance_motor_sequencer
  import fams_pkg::*;
#(
  parameter int TIME_BITS       = 32,
  parameter int TIMED_OFFSET_MS = 379
) (
  input  logic        clk,
  input  logic        rst,
  // tick queue
  input  logic        push,
  output logic        full,
  input  logic        switch_level,
  input  logic        trigger_level,
  input  logic        dir_level,
  input  logic        speed_level,
  input  logic        wait_level,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic        motor_fwd_on,
  output logic        motor_back_on,
  output logic [1:0]  blink_count,
  output logic [1:0]  blink_length,
  output logic        is_running,
  output logic        is_opening,
  output logic        is_closing,
  output logic        lapse_active,
  output logic        bulb_enabled,
  output logic signed [31:0] frame_total,
  output logic [31:0] last_frame_ms,
  output logic [31:0] mean_frame_ms,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  item_t   front_item, core_item;
  result_t core_res, out_res;
  logic    in_empty, out_full, core_ready, fire;

  // front: edge detect on accepted ticks
  fams_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (push && !full),
    .switch_level (switch_level),
    .trigger_level(trigger_level),
    .dir_level    (dir_level),
    .speed_level  (speed_level),
    .wait_level   (wait_level),
    .item         (front_item)
  );

  fams_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_in_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(front_item),
    .rd_en  (fire),
    .rd_data(core_item),
    .full   (full),
    .empty  (in_empty)
  );

  // core runs a tick when one waits, shares are settled, and result room exists
  assign fire = !in_empty && core_ready && !out_full;

  fams_back #(.TIME_BITS(TIME_BITS), .TIMED_OFFSET_MS(TIMED_OFFSET_MS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fire     (fire),
    .ready    (core_ready),
    .item     (core_item),
    .result   (core_res)
  );

  fams_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fire),
    .wr_data(core_res),
    .rd_en  (pop),
    .rd_data(out_res),
    .full   (out_full),
    .empty  (empty)
  );

  assign motor_fwd_on  = out_res.motor_fwd_on;
  assign motor_back_on = out_res.motor_back_on;
  assign blink_count   = out_res.blink_count;
  assign blink_length  = out_res.blink_length;
  assign is_running    = out_res.is_running;
  assign is_opening    = out_res.is_opening;
  assign is_closing    = out_res.is_closing;
  assign lapse_active  = out_res.lapse_active;
  assign bulb_enabled  = out_res.bulb_enabled;
  assign frame_total   = signed'(out_res.frame_total);
  assign last_frame_ms = out_res.last_frame_ms;
  assign mean_frame_ms = out_res.mean_frame_ms;

endmodule

@@ src/fams_checker.sv @@
// ----------------------------------------------------------------------------
// fams_checker
// Port level checks on the frame advance sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "frame_advance_motor_sequencer_assert.svh"

module fams_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        motor_fwd_on,
  input logic        motor_back_on,
  input logic [1:0]  blink_count,
  input logic [1:0]  blink_length,
  input logic        is_opening,
  input logic        is_closing
);

  `FAMS_ASSERT_NEVER(a_motor_excl, clk, rst, !empty && motor_fwd_on && motor_back_on)
  `FAMS_ASSERT_IMPL(a_blink_len_idle, clk, rst, !empty && blink_count == 2'd0, blink_length == 2'd0)
  `FAMS_ASSERT_NEVER(a_blink_range, clk, rst, !empty && (blink_count == 2'd3 || blink_length == 2'd3))
  `FAMS_ASSERT_NEVER(a_bulb_excl, clk, rst, !empty && is_opening && is_closing)
  `FAMS_ASSERT_NEXT(a_reset_clear, clk, rst, empty && !full)

endmodule

bind frame_advance_motor_sequencer fams_checker u_fams_checker (.*);
